### design/lpsm_pkg.sv
// ============================================================================
// lpsm_pkg: shared definitions for the literal pattern stream matcher
// Widths, register indexes and the ASCII case fold used by the matcher.
// ============================================================================
package lpsm_pkg;

    // Window depth and longest pattern in code units
    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int SKIP_W      = IDX_W;

    // Position counters (saturating)
    localparam int ROW_BITS = 16;
    localparam int COL_BITS = 12;

    // Field widths on the ports
    localparam int UNIT_W      = 16;
    localparam int UNIT_SHIFT  = 4;
    localparam int ROW_FIELD_W = 16;
    localparam int COL_FIELD_W = 12;
    localparam int PLEN_W      = 5;

    // Configuration port
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int PATTERN_WORDS  = 4;
    localparam int UNITS_PER_WORD = CFG_DATA_W / UNIT_W;
    localparam int PATTERN_UNITS  = PATTERN_WORDS * UNITS_PER_WORD;

    localparam logic [UNIT_W-1:0] NEWLINE_UNIT = 16'h000A;
    localparam logic [UNIT_W-1:0] UPPER_A      = 16'h0041;
    localparam logic [UNIT_W-1:0] UPPER_Z      = 16'h005A;
    localparam logic [UNIT_W-1:0] CASE_OFFSET  = 16'h0020;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_WORD0  = 3'd0,
        REG_PATTERN_WORD1  = 3'd1,
        REG_PATTERN_WORD2  = 3'd2,
        REG_PATTERN_WORD3  = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_CASE_SENSITIVE = 3'd5
    } cfg_reg_t;

    // Lower ASCII A..Z when the compare is case-blind
    function automatic logic [UNIT_W-1:0] fold_unit(
        input logic [UNIT_W-1:0] unit,
        input logic              case_sensitive
    );
        logic [UNIT_W-1:0] folded;
        folded = unit;
        if (!case_sensitive && (unit >= UPPER_A) && (unit <= UPPER_Z))
        begin
            folded = unit + CASE_OFFSET;
        end
        return folded;
    endfunction

endpackage

### design/literal_pattern_stream_matcher.sv
// ============================================================================
// literal_pattern_stream_matcher
// Scans a stream of screen cells against a literal pattern of UTF-16 code
// units and reports the row and column at which each non-overlapping match
// starts, unless it starts on a row separator. Row separators compare as newline.
// ============================================================================
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+--------------------------------
//  input   | in        | in_valid / in_ready   | scan_start, code_unit, is_row_end
//  result  | out       | out_valid / out_ready | match_row, match_col
//  config  | in        | cfg_wr_en             | cfg_index, cfg_data
//
//  One cell is taken per cycle unless a waiting result stalls the input. A
//  transaction lands in the input register; once it is processed, the window
//  shift, the parallel compare and the counter update run and load the result
//  register. A waiting result only stalls the input register when it cannot be
//  taken, so a new cell is accepted while a result still waits. Reset clears
//  the window, the counters and the pattern registers at once.
//
module literal_pattern_stream_matcher
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  logic [lpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpsm_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 scan_start,
    input  logic [lpsm_pkg::UNIT_W-1:0]          code_unit,
    input  logic                                 is_row_end,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lpsm_pkg::ROW_FIELD_W-1:0]     match_row,
    output logic [lpsm_pkg::COL_FIELD_W-1:0]     match_col
);

    localparam int PMAX = lpsm_pkg::PATTERN_MAX;
    localparam int UW   = lpsm_pkg::UNIT_W;
    localparam int RB   = lpsm_pkg::ROW_BITS;
    localparam int CB   = lpsm_pkg::COL_BITS;

    localparam logic [RB-1:0] ROW_MAX = {RB{1'b1}};
    localparam logic [CB-1:0] COL_MAX = {CB{1'b1}};

    // Configuration registers
    logic [lpsm_pkg::PATTERN_UNITS-1:0][UW-1:0] pattern_reg;
    logic [lpsm_pkg::PLEN_W-1:0]                pattern_length_reg;
    logic                                       case_sensitive_reg;

    // Input register
    logic          in_valid_reg;
    logic          scan_start_reg;
    logic [UW-1:0] code_unit_reg;
    logic          is_row_end_reg;

    // Window and scan state
    logic [PMAX-1:0][UW-1:0] win_units_reg, win_units_next;
    logic [PMAX-1:0][RB-1:0] win_rows_reg,  win_rows_next;
    logic [PMAX-1:0][CB-1:0] win_cols_reg,  win_cols_next;
    logic [PMAX-1:0]         win_sep_reg,   win_sep_next;
    logic [lpsm_pkg::LEN_W-1:0]  window_fill_reg, window_fill_next;
    logic [lpsm_pkg::SKIP_W-1:0] skip_count_reg,  skip_count_next;
    logic [RB-1:0]               row_counter_reg, row_counter_next;
    logic [CB-1:0]               col_counter_reg, col_counter_next;

    // Result register
    logic                                out_valid_reg;
    logic [lpsm_pkg::ROW_FIELD_W-1:0]    match_row_reg, match_row_next;
    logic [lpsm_pkg::COL_FIELD_W-1:0]    match_col_reg, match_col_next;

    // Working signals
    logic                            process;
    logic                            emit;
    logic [lpsm_pkg::LEN_W-1:0]      len;
    logic [lpsm_pkg::LEN_W-1:0]      align_shift;
    logic [PMAX-1:0][UW-1:0]         pattern_rev;
    logic [PMAX-1:0][UW-1:0]         pattern_aligned;
    logic [PMAX-1:0]                 unit_ok;
    logic [lpsm_pkg::SKIP_W-1:0]     skip_cur;
    logic [RB-1:0]                   row_cur;
    logic [CB-1:0]                   col_cur;
    logic [UW-1:0]                   unit_in;
    logic                            hit;
    logic [lpsm_pkg::IDX_W-1:0]      start_idx;

    // Handshake control: the input register moves on whenever the result slot is free or being taken
    assign process   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || process;
    assign out_valid = out_valid_reg;
    assign match_row = match_row_reg;
    assign match_col = match_col_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            pattern_length_reg <= '0;
            case_sensitive_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lpsm_pkg::REG_PATTERN_WORD0:
                    pattern_reg[0 +: lpsm_pkg::UNITS_PER_WORD] <= cfg_data;
                lpsm_pkg::REG_PATTERN_WORD1:
                    pattern_reg[lpsm_pkg::UNITS_PER_WORD +: lpsm_pkg::UNITS_PER_WORD]
                        <= cfg_data;
                lpsm_pkg::REG_PATTERN_WORD2:
                    pattern_reg[2*lpsm_pkg::UNITS_PER_WORD +: lpsm_pkg::UNITS_PER_WORD]
                        <= cfg_data;
                lpsm_pkg::REG_PATTERN_WORD3:
                    pattern_reg[3*lpsm_pkg::UNITS_PER_WORD +: lpsm_pkg::UNITS_PER_WORD]
                        <= cfg_data;
                lpsm_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[lpsm_pkg::PLEN_W-1:0];
                lpsm_pkg::REG_CASE_SENSITIVE:
                    case_sensitive_reg <= cfg_data[0];
                default:
                    pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    // Input register: hold the transaction until the compare stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            scan_start_reg <= scan_start;
            code_unit_reg  <= code_unit;
            is_row_end_reg <= is_row_end;
        end
    end

    // Clamp the pattern length and line the pattern up with the window
    always_comb
    begin
        if (pattern_length_reg > lpsm_pkg::PLEN_W'(PMAX))
        begin
            len = lpsm_pkg::LEN_W'(PMAX);
        end
        else
        begin
            len = lpsm_pkg::LEN_W'(pattern_length_reg);
        end
        align_shift = lpsm_pkg::LEN_W'(PMAX) - len;
        for (int j = 0; j < PMAX; j++)
        begin
            pattern_rev[j] = pattern_reg[PMAX-1-j];
        end
        // window slot j meets pattern unit len-1-j
        pattern_aligned = pattern_rev >> {align_shift, {lpsm_pkg::UNIT_SHIFT{1'b0}}};
    end

    // Shift the new cell into the window and advance the counters
    always_comb
    begin
        unit_in = is_row_end_reg ? lpsm_pkg::NEWLINE_UNIT : code_unit_reg;
        skip_cur = scan_start_reg ? '0 : skip_count_reg;
        row_cur  = scan_start_reg ? '0 : row_counter_reg;
        col_cur  = scan_start_reg ? '0 : col_counter_reg;

        win_units_next[0] = unit_in;
        win_rows_next[0]  = row_cur;
        win_cols_next[0]  = col_cur;
        win_sep_next[0]   = is_row_end_reg;
        for (int i = 1; i < PMAX; i++)
        begin
            win_units_next[i] = scan_start_reg ? '0   : win_units_reg[i-1];
            win_rows_next[i]  = scan_start_reg ? '0   : win_rows_reg[i-1];
            win_cols_next[i]  = scan_start_reg ? '0   : win_cols_reg[i-1];
            win_sep_next[i]   = scan_start_reg ? 1'b0 : win_sep_reg[i-1];
        end

        if (scan_start_reg)
        begin
            window_fill_next = lpsm_pkg::LEN_W'(1);
        end
        else if (window_fill_reg < lpsm_pkg::LEN_W'(PMAX))
        begin
            window_fill_next = window_fill_reg + lpsm_pkg::LEN_W'(1);
        end
        else
        begin
            window_fill_next = window_fill_reg;
        end

        if (is_row_end_reg)
        begin
            row_counter_next = (row_cur < ROW_MAX) ? row_cur + RB'(1) : row_cur;
            col_counter_next = '0;
        end
        else
        begin
            row_counter_next = row_cur;
            col_counter_next = (col_cur < COL_MAX) ? col_cur + CB'(1) : col_cur;
        end
    end

    // Compare every window slot in parallel, then pick the start entry
    always_comb
    begin
        for (int j = 0; j < PMAX; j++)
        begin
            unit_ok[j] = (lpsm_pkg::LEN_W'(j) >= len)
                || (lpsm_pkg::fold_unit(win_units_next[j], case_sensitive_reg)
                    == lpsm_pkg::fold_unit(pattern_aligned[j], case_sensitive_reg));
        end
        hit = (skip_cur == '0) && (len != '0) && (window_fill_next >= len) && (&unit_ok);
        start_idx = lpsm_pkg::IDX_W'(len - lpsm_pkg::LEN_W'(1));

        if (skip_cur != '0)
        begin
            skip_count_next = skip_cur - lpsm_pkg::SKIP_W'(1);
        end
        else if (hit)
        begin
            skip_count_next = lpsm_pkg::SKIP_W'(start_idx);
        end
        else
        begin
            skip_count_next = skip_cur;
        end

        emit           = hit && !win_sep_next[start_idx];
        match_row_next = lpsm_pkg::ROW_FIELD_W'(win_rows_next[start_idx]);
        match_col_next = lpsm_pkg::COL_FIELD_W'(win_cols_next[start_idx]);
    end

    // Scan state: advance on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_units_reg   <= '0;
            win_rows_reg    <= '0;
            win_cols_reg    <= '0;
            win_sep_reg     <= '0;
            window_fill_reg <= '0;
            skip_count_reg  <= '0;
            row_counter_reg <= '0;
            col_counter_reg <= '0;
        end
        else if (process)
        begin
            win_units_reg   <= win_units_next;
            win_rows_reg    <= win_rows_next;
            win_cols_reg    <= win_cols_next;
            win_sep_reg     <= win_sep_next;
            window_fill_reg <= window_fill_next;
            skip_count_reg  <= skip_count_next;
            row_counter_reg <= row_counter_next;
            col_counter_reg <= col_counter_next;
        end
    end

    // Result register: load on a reported match, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            match_row_reg <= match_row_next;
            match_col_reg <= match_col_next;
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        window_fill_reg <= lpsm_pkg::LEN_W'(PMAX))
        else $error("window fill beyond window depth");

    a_skip_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_count_reg == '0) || (lpsm_pkg::LEN_W'(skip_count_reg) < window_fill_reg))
        else $error("skip count not covered by window fill");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(process))
        else $error("result appeared without a processed transaction");

endmodule

### verif/literal_pattern_stream_matcher_tb.sv
// ============================================================================
// literal_pattern_stream_matcher_tb: self-checking bench for the matcher
// Drives screen cells through the valid/ready input channel with random gaps
// and random result back-pressure, keeps its own copy of the sliding window,
// the skip count and the saturating position counters, and compares every
// reported match start, field by field, with the oldest predicted one. A
// short planned sequence opens the run and random setting phases follow.
// ============================================================================
module literal_pattern_stream_matcher_tb;

    localparam int PATTERN_MAX    = lpsm_pkg::PATTERN_MAX;
    localparam int ROW_BITS       = lpsm_pkg::ROW_BITS;
    localparam int COL_BITS       = lpsm_pkg::COL_BITS;
    localparam int UNIT_W         = lpsm_pkg::UNIT_W;
    localparam int ROW_FIELD_W    = lpsm_pkg::ROW_FIELD_W;
    localparam int COL_FIELD_W    = lpsm_pkg::COL_FIELD_W;
    localparam int PLEN_W         = lpsm_pkg::PLEN_W;
    localparam int CFG_DATA_W     = lpsm_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W      = lpsm_pkg::CFG_IDX_W;
    localparam int PATTERN_WORDS  = lpsm_pkg::PATTERN_WORDS;
    localparam int UNITS_PER_WORD = lpsm_pkg::UNITS_PER_WORD;

    localparam logic [UNIT_W-1:0] NEWLINE_UNIT = lpsm_pkg::NEWLINE_UNIT;
    localparam logic [UNIT_W-1:0] UPPER_A      = lpsm_pkg::UPPER_A;
    localparam logic [UNIT_W-1:0] UPPER_Z      = lpsm_pkg::UPPER_Z;
    localparam logic [UNIT_W-1:0] CASE_OFFSET  = lpsm_pkg::CASE_OFFSET;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CELLS = 1720;
    localparam int IDLE_PERCENT = 33;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 2000;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } match_t;

    typedef enum logic { STEP_CFG, STEP_CELL } step_kind_t;

    // How the expected outcome of a planned cell is obtained
    typedef enum logic [1:0] { EXP_MODEL, EXP_NONE, EXP_MATCH } exp_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        lpsm_pkg::cfg_reg_t    sel;
        logic [CFG_DATA_W-1:0] value;
        logic                  start;
        logic [UNIT_W-1:0]     cu;
        logic                  row_end;
        exp_kind_t             want;
        match_t                typed;
    } plan_step_t;

    // Block ports
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = lpsm_pkg::REG_PATTERN_WORD0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic                   scan_start = 1'b0;
    logic [UNIT_W-1:0]      code_unit  = '0;
    logic                   is_row_end = 1'b0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [ROW_FIELD_W-1:0] match_row;
    logic [COL_FIELD_W-1:0] match_col;

    // Outcome attached to the cell currently offered
    exp_kind_t              cell_want  = EXP_MODEL;
    match_t                 cell_typed = '0;

    // Matcher settings and scan state as predicted
    logic [CFG_DATA_W-1:0]  pat_words [PATTERN_WORDS];
    logic [PLEN_W-1:0]      pat_len;
    logic                   pat_exact;
    logic [UNIT_W-1:0]      win_unit [PATTERN_MAX];
    logic [ROW_BITS-1:0]    win_row  [PATTERN_MAX];
    logic [COL_BITS-1:0]    win_col  [PATTERN_MAX];
    logic                   win_sep  [PATTERN_MAX];
    int                     win_fill;
    int                     skip_left;
    logic [ROW_BITS-1:0]    row_pos;
    logic [COL_BITS-1:0]    col_pos;

    match_t                 pending_matches [$];
    plan_step_t             plan [$];

    bit                     tx_calm = 1'b0;
    bit                     rx_calm = 1'b0;
    int                     err_count    = 0;
    int                     cells_sent   = 0;
    int                     results_seen = 0;
    int                     cycle_count  = 0;

    literal_pattern_stream_matcher u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scan_start (scan_start),
        .code_unit  (code_unit),
        .is_row_end (is_row_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .match_row  (match_row),
        .match_col  (match_col)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Fold ASCII capitals when the compare is case-blind
    function automatic logic [UNIT_W-1:0] lower_ascii(input logic [UNIT_W-1:0] u);
        if (!pat_exact && u >= UPPER_A && u <= UPPER_Z)
        begin
            return u + CASE_OFFSET;
        end
        return u;
    endfunction

    function automatic logic [UNIT_W-1:0] pattern_at(input int k);
        return pat_words[k / UNITS_PER_WORD][UNIT_W * (k % UNITS_PER_WORD) +: UNIT_W];
    endfunction

    function automatic int pattern_span();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            win_unit[i] = '0;
            win_row[i]  = '0;
            win_col[i]  = '0;
            win_sep[i]  = 1'b0;
        end
        win_fill  = 0;
        skip_left = 0;
        row_pos   = '0;
        col_pos   = '0;
    endtask

    // Advance the scan by one cell and report a match start, if any
    task automatic scan_cell(input logic start, input logic [UNIT_W-1:0] cu_in,
                             input logic row_end, output bit found, output match_t hit);
        logic [UNIT_W-1:0] cu;
        int                span;
        bit                same;
        cu    = row_end ? NEWLINE_UNIT : cu_in;
        span  = pattern_span();
        found = 1'b0;
        hit   = '0;
        if (start)
        begin
            clear_window();
        end

        // Shift the window, newest entry at the front
        for (int i = PATTERN_MAX - 1; i > 0; i--)
        begin
            win_unit[i] = win_unit[i-1];
            win_row[i]  = win_row[i-1];
            win_col[i]  = win_col[i-1];
            win_sep[i]  = win_sep[i-1];
        end
        win_unit[0] = cu;
        win_row[0]  = row_pos;
        win_col[0]  = col_pos;
        win_sep[0]  = row_end;
        if (win_fill < PATTERN_MAX)
        begin
            win_fill++;
        end

        // Saturating position counters
        if (row_end)
        begin
            if (row_pos != '1)
            begin
                row_pos++;
            end
            col_pos = '0;
        end
        else if (col_pos != '1)
        begin
            col_pos++;
        end

        // Compare unless an accepted match still blocks overlap
        if (skip_left > 0)
        begin
            skip_left--;
        end
        else if (span > 0 && win_fill >= span)
        begin
            same = 1'b1;
            for (int k = 0; k < span; k++)
            begin
                if (lower_ascii(pattern_at(k)) != lower_ascii(win_unit[span-1-k]))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                skip_left = span - 1;
                if (!win_sep[span-1])
                begin
                    found   = 1'b1;
                    hit.row = win_row[span-1];
                    hit.col = win_col[span-1];
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write one register; the caller keeps the block idle
    task automatic write_reg(input lpsm_pkg::cfg_reg_t sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        case (sel)
            lpsm_pkg::REG_PATTERN_WORD0:  pat_words[0] = value;
            lpsm_pkg::REG_PATTERN_WORD1:  pat_words[1] = value;
            lpsm_pkg::REG_PATTERN_WORD2:  pat_words[2] = value;
            lpsm_pkg::REG_PATTERN_WORD3:  pat_words[3] = value;
            lpsm_pkg::REG_PATTERN_LENGTH: pat_len      = value[PLEN_W-1:0];
            lpsm_pkg::REG_CASE_SENSITIVE: pat_exact    = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drain all expected results, then give the pipeline time to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Offer one cell and hold it until the transaction completes
    task automatic push_cell(input logic start, input logic [UNIT_W-1:0] cu,
                             input logic row_end, input exp_kind_t want, input match_t typed);
        cfg_wr_en <= 1'b0;
        while (!tx_calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        scan_start <= start;
        code_unit  <= cu;
        is_row_end <= row_end;
        cell_want  <= want;
        cell_typed <= typed;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        cells_sent++;
        @(negedge clk);
    endtask

    // Randomly stall the result channel
    always @(negedge clk)
    begin
        out_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every input transaction, check every result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        bit     found;
        match_t predicted;
        match_t oldest;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                scan_cell(scan_start, code_unit, is_row_end, found, predicted);
                if (cell_want == EXP_MATCH)
                begin
                    pending_matches.push_back(cell_typed);
                end
                else if (cell_want == EXP_MODEL && found)
                begin
                    pending_matches.push_back(predicted);
                end
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_matches.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result expected none, actual row %0d col %0d",
                             $time, match_row, match_col);
                end
                else
                begin
                    oldest = pending_matches.pop_front();
                    if (match_row !== oldest.row)
                    begin
                        err_count++;
                        $display("%0t: match_row expected %0d actual %0d",
                                 $time, oldest.row, match_row);
                    end
                    if (match_col !== oldest.col)
                    begin
                        err_count++;
                        $display("%0t: match_col expected %0d actual %0d",
                                 $time, oldest.col, match_col);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Text units drawn mostly from a small alphabet so that matches occur
    function automatic logic [UNIT_W-1:0] pick_text_unit(input bit wide);
        case ($urandom_range(wide ? 9 : 5))
            0:       return 16'h0061;
            1:       return 16'h0062;
            2:       return UPPER_A;
            3:       return 16'h0042;
            4:       return NEWLINE_UNIT;
            5:       return 16'h0063;
            default: return UNIT_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic plan_cfg(input lpsm_pkg::cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        plan_step_t s;
        s       = '0;
        s.kind  = STEP_CFG;
        s.sel   = sel;
        s.value = value;
        plan.push_back(s);
    endtask

    task automatic plan_cell(input logic start, input logic [UNIT_W-1:0] cu, input logic row_end,
                             input exp_kind_t want, input int row, input int col);
        plan_step_t s;
        s           = '0;
        s.kind      = STEP_CELL;
        s.start     = start;
        s.cu        = cu;
        s.row_end   = row_end;
        s.want      = want;
        s.typed.row = ROW_FIELD_W'(row);
        s.typed.col = COL_FIELD_W'(col);
        plan.push_back(s);
    endtask

    // One phase of random settings followed by random text
    task automatic run_random_phase(input int phase_no);
        logic [CFG_DATA_W-1:0] words [PATTERN_WORDS];
        logic [UNIT_W-1:0]     cu;
        int                    len;
        int                    span;
        int                    base;
        int                    n_cells;
        int                    pick;
        int                    spoil;
        logic                  mark;

        settle();
        if (phase_no >= 6 && phase_no < 12)
        begin
            tx_calm = 1'b1;
            rx_calm = 1'b1;
        end
        else
        begin
            tx_calm = ($urandom_range(5) == 0);
            rx_calm = ($urandom_range(5) == 0);
        end

        // New pattern words, length and compare mode, each only sometimes
        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            for (int k = 0; k < UNITS_PER_WORD; k++)
            begin
                words[w][UNIT_W*k +: UNIT_W] = pick_text_unit($urandom_range(7) == 0);
            end
            if ($urandom_range(9) < 7)
            begin
                write_reg(lpsm_pkg::cfg_reg_t'(lpsm_pkg::REG_PATTERN_WORD0 + w), words[w]);
            end
        end
        case ($urandom_range(9))
            0:       len = 0;
            1:       len = 1;
            2, 3, 4: len = $urandom_range(4, 2);
            5:       len = $urandom_range(PATTERN_MAX - 1, 5);
            6:       len = PATTERN_MAX;
            7:       len = $urandom_range(31, PATTERN_MAX + 1);
            default: len = $urandom_range(PATTERN_MAX, 1);
        endcase
        if ($urandom_range(9) < 8)
        begin
            write_reg(lpsm_pkg::REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        end
        if ($urandom_range(9) < 6)
        begin
            write_reg(lpsm_pkg::REG_CASE_SENSITIVE, CFG_DATA_W'($urandom_range(1)));
        end

        span    = pattern_span();
        base    = cells_sent;
        n_cells = $urandom_range(90, 15);
        mark    = ($urandom_range(1) == 1);
        while (cells_sent - base < n_cells)
        begin
            if ($urandom_range(79) == 0)
            begin
                mark = 1'b1;
            end
            pick = $urandom_range(99);
            if (span > 0 && pick < 45)
            begin
                // Pattern copy with random case, sometimes with one unit spoilt
                spoil = ($urandom_range(4) == 0) ? $urandom_range(span - 1) : -1;
                for (int k = 0; k < span; k++)
                begin
                    cu = (k == spoil) ? pick_text_unit(1'b1) : pattern_at(k);
                    if (cu == NEWLINE_UNIT && $urandom_range(3) != 0)
                    begin
                        push_cell(mark, UNIT_W'($urandom_range(65535)), 1'b1, EXP_MODEL, '0);
                    end
                    else
                    begin
                        if ($urandom_range(1) == 1
                            && ((cu >= UPPER_A && cu <= UPPER_Z)
                                || (cu >= UPPER_A + CASE_OFFSET && cu <= UPPER_Z + CASE_OFFSET)))
                        begin
                            cu = cu ^ CASE_OFFSET;
                        end
                        push_cell(mark, cu, 1'b0, EXP_MODEL, '0);
                    end
                    mark = 1'b0;
                end
            end
            else if (pick < 60)
            begin
                push_cell(mark, UNIT_W'($urandom_range(65535)), 1'b1, EXP_MODEL, '0);
            end
            else if (pick < 90)
            begin
                push_cell(mark, pick_text_unit(1'b0), 1'b0, EXP_MODEL, '0);
            end
            else
            begin
                push_cell(mark, UNIT_W'($urandom_range(65535)), 1'b0, EXP_MODEL, '0);
            end
            mark = 1'b0;
        end
    endtask

    initial
    begin
        int phase_no;
        int planned_cells;
        int waited;

        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            pat_words[w] = '0;
        end
        pat_len   = '0;
        pat_exact = 1'b0;
        clear_window();
        phase_no  = 0;
        waited    = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty pattern after reset: nothing can match
        plan_cell(1'b1, 16'h0000, 1'b0, EXP_NONE, 0, 0);
        plan_cell(1'b0, 16'hFFFF, 1'b1, EXP_NONE, 0, 0);

        // "Ab" folded: mixed case on both sides, a row break between hits
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0062_0041);
        plan_cfg(lpsm_pkg::REG_PATTERN_LENGTH, 2);
        plan_cfg(lpsm_pkg::REG_CASE_SENSITIVE, 0);
        plan_cell(1'b1, 16'h0061, 1'b0, EXP_NONE, 0, 0);
        plan_cell(1'b0, 16'h0042, 1'b0, EXP_MATCH, 0, 0);
        plan_cell(1'b0, 16'h0000, 1'b1, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0061, 1'b0, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0062, 1'b0, EXP_MATCH, 1, 0);

        // Newline then "A": matches that start on a separator stay silent
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0041_000A);
        plan_cell(1'b1, 16'h1234, 1'b1, EXP_NONE, 0, 0);
        plan_cell(1'b0, 16'h0061, 1'b0, EXP_NONE, 0, 0);
        plan_cell(1'b0, 16'h0000, 1'b1, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0041, 1'b0, EXP_NONE, 0, 0);

        // Exact compare mid-scan
        plan_cfg(lpsm_pkg::REG_CASE_SENSITIVE, 1);
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0062_0041);
        plan_cell(1'b0, 16'h0061, 1'b0, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0062, 1'b0, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0041, 1'b0, EXP_MODEL, 0, 0);
        plan_cell(1'b0, 16'h0062, 1'b0, EXP_MODEL, 0, 0);

        // Oversized length clamps to a full window of all-ones units
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD1, '1);
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD2, '1);
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD3, '1);
        plan_cfg(lpsm_pkg::REG_PATTERN_WORD0, '1);
        plan_cfg(lpsm_pkg::REG_PATTERN_LENGTH, 31);
        plan_cell(1'b1, 16'hFFFF, 1'b0, EXP_MODEL, 0, 0);
        for (int i = 1; i < PATTERN_MAX - 1; i++)
        begin
            plan_cell(1'b0, 16'hFFFF, 1'b0, EXP_MODEL, 0, 0);
        end
        plan_cell(1'b0, 16'hFFFF, 1'b0, EXP_MATCH, 0, 0);
        plan_cell(1'b0, 16'hFFFF, 1'b0, EXP_NONE, 0, 0);

        // Walk the plan, settling before each group of writes
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                if (i == 0 || plan[i-1].kind == STEP_CELL)
                begin
                    settle();
                end
                write_reg(plan[i].sel, plan[i].value);
            end
            else
            begin
                push_cell(plan[i].start, plan[i].cu, plan[i].row_end,
                          plan[i].want, plan[i].typed);
            end
        end
        planned_cells = cells_sent;

        // Random setting phases
        while (cells_sent < planned_cells + RANDOM_CELLS)
        begin
            run_random_phase(phase_no);
            phase_no++;
        end

        // Drain outstanding results
        in_valid <= 1'b0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_matches.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_matches.size());
        end

        $display("Scanned %0d cells over %0d random setting phases plus the planned",
                 cells_sent, phase_no);
        $display("sequence; %0d match reports checked.", results_seen);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
